[rtl/ookmpd_pkg.sv]
`timescale 1ns / 1ps

package ookmpd_pkg;

    // Fixed field widths.
    localparam int WIDTH_W    = 16;
    localparam int VER_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int OUT_CNT_W  = 5;

    // Internal widths, sized for the largest supported buffer of 64 bytes.
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;

    // Depth of the command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_VERSION   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_MIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_SPLIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_MIN   = 3'd4;

    // Protocol versions.
    localparam logic [VER_W-1:0] VER_NONE = 2'd0;
    localparam logic [VER_W-1:0] VER_1    = 2'd1;
    localparam logic [VER_W-1:0] VER_2    = 2'd2;
    localparam logic [VER_W-1:0] VER_3    = 2'd3;

    // Reset values of the thresholds.
    localparam logic [WIDTH_W-1:0] SHORT_MIN_RST  = 16'd200;
    localparam logic [WIDTH_W-1:0] LONG_SPLIT_RST = 16'd700;
    localparam logic [WIDTH_W-1:0] DATA_MAX_RST   = 16'd1200;
    localparam logic [WIDTH_W-1:0] GAP_MIN_RST    = 16'd2500;

    // Preamble and frame length rules.
    localparam logic [7:0] V1_START_MIN  = 8'd10;
    localparam logic [7:0] V1_START_MAX  = 8'd50;
    localparam logic [7:0] V2_PREAMBLE   = 8'd24;
    localparam logic [7:0] V3_PREAMBLE   = 8'd32;
    localparam logic [7:0] V2_FRAME_BITS = 8'd160;
    localparam logic [7:0] V3_FRAME_BITS = 8'd80;
    localparam int         V1_MIN_BYTES  = 9;
    localparam int         V2_MIN_BYTES  = 8;

    typedef enum logic [2:0] {
        PH_UNKNOWN = 3'b001,
        PH_T0      = 3'b010,
        PH_OK      = 3'b100
    } phase_t;

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_FETCH = 3'b010,
        B_SHOW  = 3'b100
    } back_state_t;

    // One command from the front part to the back part. Every command
    // carries at most one buffer write and yields one result or a run.
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [7:0]       wr_data;
        logic             run;
        logic             done;
        logic [CNT_W-1:0] count;
    } cmd_t;

endpackage

[rtl/ookmpd_front.sv]
`timescale 1ns / 1ps

module ookmpd_front #(
    parameter int BUFFER_BYTES = 25
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ookmpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ookmpd_pkg::WIDTH_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [ookmpd_pkg::WIDTH_W-1:0]    pulse_width,
    output logic                              push,
    output ookmpd_pkg::cmd_t                  cmd,
    input  logic                              full
);
    import ookmpd_pkg::*;

    localparam int            PW   = $clog2(BUFFER_BYTES + 1);
    localparam logic [PW-1:0] B_PW = PW'(BUFFER_BYTES);
    localparam logic [7:0]    B8   = 8'(BUFFER_BYTES);

    logic [VER_W-1:0]   ver_reg, ver_next;
    logic [WIDTH_W-1:0] smin_reg, smin_next;
    logic [WIDTH_W-1:0] lsplit_reg, lsplit_next;
    logic [WIDTH_W-1:0] dmax_reg, dmax_next;
    logic [WIDTH_W-1:0] gmin_reg, gmin_next;
    phase_t             phase_reg, phase_next;
    logic [7:0]         flip_reg, flip_next;
    logic [7:0]         total_reg, total_next;
    logic [2:0]         bib_reg, bib_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic [7:0]         acc_reg, acc_next;

    logic          accept, cfg_we;
    logic          is_data, is_long, is_gap, start_ok;
    logic          do_store, store_v, do_clear, do_done, pad_over;
    logic [7:0]    total_inc, pos_wide, shifted, padded;
    logic [PW-1:0] pos_plus, pad_plus;
    logic [3:0]    pad_shift;
    cmd_t          cmd_c;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid;
    assign in_stall  = full;
    assign accept    = in_valid && !full;
    assign push      = accept;
    assign cmd       = cmd_c;

    always_comb
    begin
        ver_next    = ver_reg;
        smin_next   = smin_reg;
        lsplit_next = lsplit_reg;
        dmax_next   = dmax_reg;
        gmin_next   = gmin_reg;
        phase_next  = phase_reg;
        flip_next   = flip_reg;
        total_next  = total_reg;
        bib_next    = bib_reg;
        pos_next    = pos_reg;
        acc_next    = acc_reg;

        cmd_c         = '0;
        is_data       = (pulse_width >= smin_reg) && (pulse_width < dmax_reg);
        is_long       = pulse_width >= lsplit_reg;
        is_gap        = pulse_width >= gmin_reg;
        start_ok      = (ver_reg == VER_1) ?
                        ((flip_reg >= V1_START_MIN) && (flip_reg <= V1_START_MAX)) :
                        (flip_reg >= V3_PREAMBLE);
        do_store      = 1'b0;
        store_v       = 1'b0;
        do_clear      = 1'b0;
        do_done       = 1'b0;
        pad_over      = 1'b0;
        total_inc     = total_reg + 8'd1;
        pos_wide      = '0;
        shifted       = '0;
        padded        = '0;
        pos_plus      = pos_reg + PW'(1);
        pad_plus      = '0;
        pad_shift     = '0;

        if (accept)
        begin
            // Classify the pulse and advance the Manchester decoder.
            if (is_data)
            begin
                unique case (phase_reg)
                    PH_UNKNOWN:
                    begin
                        if (ver_reg == VER_2)
                        begin
                            priority if (is_long)
                                flip_next = flip_reg + 8'd1;
                            else if (flip_reg >= V2_PREAMBLE)
                            begin
                                flip_next  = 8'd0;
                                phase_next = PH_T0;
                            end
                            else
                                do_clear = 1'b1;
                        end
                        else
                        begin
                            priority if (!is_long)
                                flip_next = flip_reg + 8'd1;
                            else if (start_ok)
                            begin
                                // Count set to one, then toggled by the long pulse.
                                flip_next = 8'd0;
                                do_store  = 1'b1;
                                store_v   = 1'b0;
                            end
                            else
                                do_clear = 1'b1;
                        end
                    end
                    PH_OK:
                    begin
                        if (!is_long)
                            phase_next = PH_T0;
                        else
                        begin
                            flip_next = flip_reg ^ 8'd1;
                            do_store  = 1'b1;
                            store_v   = ~flip_reg[0];
                        end
                    end
                    PH_T0:
                    begin
                        if (!is_long)
                        begin
                            do_store = 1'b1;
                            store_v  = flip_reg[0];
                        end
                        else
                            do_clear = 1'b1;
                    end
                    default:
                        do_clear = 1'b1;
                endcase
            end
            else
            begin
                priority if (((ver_reg == VER_1) && is_gap && (pos_reg >= PW'(V1_MIN_BYTES))) ||
                             ((ver_reg == VER_2) && is_gap && (pos_reg >= PW'(V2_MIN_BYTES))))
                    do_done = 1'b1;
                else
                    do_clear = 1'b1;
            end

            // Store one decoded bit into the byte under assembly.
            shifted = {store_v, acc_reg[7:1]};
            if (do_store)
            begin
                if (pos_reg >= B_PW)
                    do_clear = 1'b1;
                else
                begin
                    phase_next = PH_OK;
                    unique case (ver_reg)
                        VER_1:
                        begin
                            acc_next      = shifted;
                            cmd_c.wr_en   = 1'b1;
                            cmd_c.wr_addr = IDX_W'(pos_reg);
                            cmd_c.wr_data = shifted;
                            total_next    = total_inc;
                            bib_next      = bib_reg + 3'd1;
                            if (bib_reg == 3'd7)
                            begin
                                if (pos_plus >= B_PW)
                                    do_clear = 1'b1;
                                else
                                    pos_next = pos_plus;
                            end
                        end
                        VER_2:
                        begin
                            // Only every other bit lands in the buffer.
                            if (!total_reg[0])
                            begin
                                acc_next      = shifted;
                                cmd_c.wr_en   = 1'b1;
                                cmd_c.wr_addr = IDX_W'(pos_reg);
                                cmd_c.wr_data = shifted;
                            end
                            total_next = total_inc;
                            pos_wide   = {4'd0, total_inc[7:4]};
                            if (pos_wide >= B8)
                                do_clear = 1'b1;
                            else
                                pos_next = pos_wide[PW-1:0];
                        end
                        default:
                        begin
                            acc_next      = shifted;
                            cmd_c.wr_en   = 1'b1;
                            cmd_c.wr_addr = IDX_W'(pos_reg);
                            cmd_c.wr_data = shifted;
                            total_next    = total_inc;
                            pos_wide      = {3'd0, total_inc[7:3]};
                            if (pos_wide >= B8)
                                do_clear = 1'b1;
                            else
                                pos_next = pos_wide[PW-1:0];
                        end
                    endcase
                end
            end

            // Fixed-length frames complete on their bit total.
            if (is_data && !do_clear)
            begin
                if (((ver_reg == VER_2) && (total_next == V2_FRAME_BITS)) ||
                    ((ver_reg == VER_3) && (total_next == V3_FRAME_BITS)))
                    do_done = 1'b1;
            end

            if (do_done)
            begin
                // Pad a partial byte with zero bits, then hand the frame over.
                cmd_c.done = 1'b1;
                if (bib_next != 3'd0)
                begin
                    pad_shift     = 4'd8 - {1'b0, bib_next};
                    padded        = acc_next >> pad_shift;
                    pad_plus      = pos_next + PW'(1);
                    pad_over      = pad_plus >= B_PW;
                    acc_next      = padded;
                    cmd_c.wr_en   = 1'b1;
                    cmd_c.wr_addr = IDX_W'(pos_next);
                    cmd_c.wr_data = padded;
                    cmd_c.count   = pad_over ? '0 : CNT_W'(pad_plus);
                end
                else
                    cmd_c.count = CNT_W'(pos_next);
                cmd_c.run = cmd_c.count != '0;
            end

            if (do_clear || do_done)
            begin
                phase_next = PH_UNKNOWN;
                flip_next  = '0;
                total_next = '0;
                bib_next   = '0;
                pos_next   = '0;
            end
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VERSION:
                begin
                    if (cfg_data[VER_W-1:0] != VER_NONE)
                    begin
                        ver_next   = cfg_data[VER_W-1:0];
                        phase_next = PH_UNKNOWN;
                        flip_next  = '0;
                        total_next = '0;
                        bib_next   = '0;
                        pos_next   = '0;
                    end
                end
                REG_SHORT_MIN:  smin_next   = cfg_data;
                REG_LONG_SPLIT: lsplit_next = cfg_data;
                REG_DATA_MAX:   dmax_next   = cfg_data;
                REG_GAP_MIN:    gmin_next   = cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ver_reg    <= VER_1;
            smin_reg   <= SHORT_MIN_RST;
            lsplit_reg <= LONG_SPLIT_RST;
            dmax_reg   <= DATA_MAX_RST;
            gmin_reg   <= GAP_MIN_RST;
            phase_reg  <= PH_UNKNOWN;
            flip_reg   <= '0;
            total_reg  <= '0;
            bib_reg    <= '0;
            pos_reg    <= '0;
        end
        else
        begin
            ver_reg    <= ver_next;
            smin_reg   <= smin_next;
            lsplit_reg <= lsplit_next;
            dmax_reg   <= dmax_next;
            gmin_reg   <= gmin_next;
            phase_reg  <= phase_next;
            flip_reg   <= flip_next;
            total_reg  <= total_next;
            bib_reg    <= bib_next;
            pos_reg    <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

endmodule

[rtl/ookmpd_queue.sv]
`timescale 1ns / 1ps

module ookmpd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ookmpd_pkg::cmd_t push_cmd,
    output logic             full,
    input  logic             pop,
    output ookmpd_pkg::cmd_t pop_cmd,
    output logic             avail
);
    import ookmpd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_Q = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_Q-1:0] fill_reg, fill_next;
    logic             do_push, do_pop;

    assign full    = fill_reg == CNT_Q'(QUEUE_DEPTH);
    assign avail   = fill_reg != '0;
    assign do_push = push && !full;
    assign do_pop  = pop && avail;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            fill_next = fill_reg + CNT_Q'(1);
        else if (do_pop && !do_push)
            fill_next = fill_reg - CNT_Q'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

[rtl/ookmpd_back.sv]
`timescale 1ns / 1ps

module ookmpd_back #(
    parameter int BUFFER_BYTES = 25
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    input  ookmpd_pkg::cmd_t                  cmd,
    output logic                              cmd_pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              frame_done,
    output logic [ookmpd_pkg::OUT_CNT_W-1:0]  byte_count,
    output logic [ookmpd_pkg::OUT_CNT_W-1:0]  byte_index,
    output logic [7:0]                        data_byte,
    output logic                              last_result
);
    import ookmpd_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);

    logic [7:0]       mem [BUFFER_BYTES];
    logic [7:0]       rd_data_reg;
    back_state_t      state_reg, state_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic             last_reg, last_next;
    logic             sel_reg, sel_next;

    assign cmd_pop     = (state_reg == B_IDLE) && cmd_valid;
    assign out_valid   = state_reg == B_SHOW;
    assign frame_done  = done_reg;
    assign byte_count  = count_reg[OUT_CNT_W-1:0];
    assign byte_index  = k_reg[OUT_CNT_W-1:0];
    assign data_byte   = sel_reg ? rd_data_reg : 8'd0;
    assign last_result = last_reg;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        count_next = count_reg;
        run_next   = run_reg;
        done_next  = done_reg;
        last_next  = last_reg;
        sel_next   = sel_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    k_next = '0;
                    if (cmd.run)
                    begin
                        run_next   = 1'b1;
                        count_next = cmd.count;
                        state_next = B_FETCH;
                    end
                    else
                    begin
                        run_next   = 1'b0;
                        done_next  = cmd.done;
                        count_next = '0;
                        last_next  = 1'b1;
                        sel_next   = 1'b0;
                        state_next = B_SHOW;
                    end
                end
            end
            B_FETCH:
            begin
                done_next  = 1'b1;
                last_next  = (k_reg + CNT_W'(1)) == count_reg;
                sel_next   = 1'b1;
                state_next = B_SHOW;
            end
            B_SHOW:
            begin
                if (!out_stall)
                begin
                    if (run_reg && !last_reg)
                    begin
                        k_next     = k_reg + CNT_W'(1);
                        state_next = B_FETCH;
                    end
                    else
                        state_next = B_IDLE;
                end
            end
            default:
                state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            k_reg     <= '0;
            count_reg <= '0;
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            last_reg  <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            count_reg <= count_next;
            run_reg   <= run_next;
            done_reg  <= done_next;
            last_reg  <= last_next;
            sel_reg   <= sel_next;
        end
    end

    // Frame buffer: written when a command is taken, read one byte per fetch.
    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd.wr_en)
            mem[cmd.wr_addr[AW-1:0]] <= cmd.wr_data;
        if (state_reg == B_FETCH)
            rd_data_reg <= mem[k_reg[AW-1:0]];
    end

endmodule

[rtl/ook_manchester_pulse_decoder_unit.sv]
`timescale 1ns / 1ps

// A pulse that completes no frame is written into the queue, then popped by the back, which
// shows its result. Throughput: the front takes one pulse per cycle while its two-entry queue
// has room; the back takes a new command only from its idle state, and passes through a fetch
// state before each frame byte, set by the frame buffer's registered read port.
// Reset: control state clears and the thresholds take their defaults at once; the frame
// buffer is not cleared, and no clearing pass runs after reset.

module ook_manchester_pulse_decoder_unit #(
    parameter int BUFFER_BYTES = 25
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ookmpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ookmpd_pkg::WIDTH_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [ookmpd_pkg::WIDTH_W-1:0]    pulse_width,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              frame_done,
    output logic [ookmpd_pkg::OUT_CNT_W-1:0]  byte_count,
    output logic [ookmpd_pkg::OUT_CNT_W-1:0]  byte_index,
    output logic [7:0]                        data_byte,
    output logic                              last_result
);
    import ookmpd_pkg::*;

    // The front part classifies each pulse, runs the preamble counter and the
    // Manchester decoder, and turns every pulse into one command. A command
    // carries the buffer write that the pulse causes, if any, and says whether
    // the pulse yields one plain result or a frame read-out.
    // The back part owns the frame buffer. It applies the writes in order and
    // streams the results, so a read-out never sees bytes of a later frame.
    logic push;
    logic full;
    logic pop;
    logic avail;
    cmd_t push_cmd;
    cmd_t pop_cmd;

    ookmpd_front #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pulse_width (pulse_width),
        .push        (push),
        .cmd         (push_cmd),
        .full        (full)
    );

    // A short queue lets the front keep taking pulses while a read-out runs.
    ookmpd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .avail    (avail)
    );

    ookmpd_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (avail),
        .cmd         (pop_cmd),
        .cmd_pop     (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_done  (frame_done),
        .byte_count  (byte_count),
        .byte_index  (byte_index),
        .data_byte   (data_byte),
        .last_result (last_result)
    );

    // A result outside a frame read-out is a single, empty result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_done |-> last_result && (byte_count == '0) &&
                                     (byte_index == '0) && (data_byte == 8'd0))
        else $error("plain result carries frame data");

    // The last byte of a read-out sits at the end of the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done && (byte_count != '0) && last_result |->
            byte_index == byte_count - OUT_CNT_W'(1))
        else $error("read-out ends at the wrong byte");

    // An empty frame is reported by one result alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done && (byte_count == '0) |-> last_result && (data_byte == 8'd0))
        else $error("empty frame result malformed");

endmodule
